// ----- design/scored_word_table_with_aging_defines.svh -----
// Assertion macros for the scored word table.
// Used by the top level; needs clk and rst_n in scope.
`ifndef SCORED_WORD_TABLE_WITH_AGING_DEFINES_SVH
`define SCORED_WORD_TABLE_WITH_AGING_DEFINES_SVH
`ifndef SYNTHESIS
`define SWTA_CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swta check failed");
`define SWTA_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swta check failed");
`else
`define SWTA_CHK_SAME(lbl, ante, cons)
`define SWTA_CHK_NEXT(lbl, ante, cons)
`endif
`endif

// ----- design/swta_pkg.sv -----
// Shared types and constants of the scored word table.
// No dependencies.
`default_nettype none
package swta_pkg;
  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int FILL_W = IDX_W + 1;
  localparam logic [7:0] SCORE_LIMIT = 8'd255;
  localparam logic [4:0] MAX_LETTERS = 5'd16;
  localparam int MAX_HITS = 8;
  localparam int HIT_W = $clog2(MAX_HITS);
  localparam int CNT_W = HIT_W + 1;
  localparam int META_W = 109;

  typedef enum logic [1:0] {
    KIND_LEARN = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  localparam logic [2:0] OUT_BUMPED   = 3'd0;
  localparam logic [2:0] OUT_INSERTED = 3'd1;
  localparam logic [2:0] OUT_REPLACED = 3'd2;
  localparam logic [2:0] OUT_QUERY    = 3'd3;
  localparam logic [2:0] OUT_CLEARED  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_BUMP,
    ST_HALVE,
    ST_INSERT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic       clr;
    logic       ins;
    logic [7:0] idx;
    logic [7:0] score;
  } rank_cmd_t;
endpackage
`default_nettype wire

// ----- design/scored_word_table_with_aging.sv -----
// Top level of the scored word table with aging and ranked lookup.
// Depends on swta_pkg, swta_ram, swta_rank and the defines header.
//
//  channel | signals                       | contents
//  in      | in_tvalid/tready/tdata/tuser  | learn, query or clear request
//  out     | out_tvalid/tready/tdata/tuser | one or more results, tlast on final
//
// Learn and query scan the filled slots one per cycle; a bump that triggers
// halving of all scores adds a second pass over the filled slots.
// The table RAM read port sets the pace.
// Reset empties the table; no clearing pass is needed.
// A stalled result holds the block; no new request is taken until the last
// result transfers.
`default_nettype none
`include "scored_word_table_with_aging_defines.svh"
module scored_word_table_with_aging (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // lang[1:0], packed_seq[33:2], seq_len[38:34], word_key[102:39],
  // word_len[108:103], hit_limit[112:109], zero fill
  input  wire logic [119:0] in_tdata,
  // kind[1:0]
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // entry_index[7:0], score[15:8]
  output logic      [15:0]  out_tdata,
  // outcome[2:0], match_valid[3]
  output logic      [3:0]   out_tuser,
  output logic              out_tlast
);
  swta_pkg::state_t state_r, state_nxt;

  logic                        query_r;
  logic [1:0]                  lang_r;
  logic [31:0]                 seq_r;
  logic [4:0]                  slen_r;
  logic [63:0]                 key_r;
  logic [5:0]                  wlen_r;
  logic [3:0]                  cap_r;
  logic [swta_pkg::FILL_W-1:0] fill_r;
  logic [swta_pkg::FILL_W-1:0] rd_r;
  logic                        pend_r;
  logic [swta_pkg::IDX_W-1:0]  pidx_r;
  logic [swta_pkg::IDX_W-1:0]  min_idx_r;
  logic [7:0]                  min_sc_r;
  logic [swta_pkg::IDX_W-1:0]  hit_idx_r;
  logic [7:0]                  hit_sc_r;
  logic [2:0]                  res_out_r;
  logic [7:0]                  res_idx_r;
  logic [7:0]                  res_sc_r;
  logic [swta_pkg::HIT_W-1:0]  qk_r;

  logic                        accept;
  logic                        issue;
  logic                        scan_done;
  logic                        learn_hit;
  logic                        query_hit;
  logic                        query_ok;
  logic [3:0]                  cap_in;
  logic [7:0]                  bump_sc;
  logic [7:0]                  halve_in;
  logic [7:0]                  halve_out;
  logic                        out_last;
  logic                        out_xfer;

  logic                        meta_we;
  logic [swta_pkg::IDX_W-1:0]  meta_waddr;
  logic [swta_pkg::META_W-1:0] meta_wdata;
  logic [swta_pkg::META_W-1:0] meta_q;
  logic                        sc_we;
  logic [swta_pkg::IDX_W-1:0]  sc_waddr;
  logic [7:0]                  sc_wdata;
  logic [7:0]                  sc_q;

  logic [1:0]                  e_lang;
  logic [31:0]                 e_seq;
  logic [4:0]                  e_slen;
  logic [63:0]                 e_key;
  logic [5:0]                  e_wlen;

  swta_pkg::rank_cmd_t         rank_cmd;
  logic [swta_pkg::CNT_W-1:0]  found;
  logic [7:0]                  list_idx [swta_pkg::MAX_HITS];
  logic [7:0]                  list_sc  [swta_pkg::MAX_HITS];

  swta_ram #(.WIDTH(swta_pkg::META_W), .DEPTH(swta_pkg::TABLE_ENTRIES)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (rd_r[swta_pkg::IDX_W-1:0]),
    .rdata (meta_q)
  );

  swta_ram #(.WIDTH(8), .DEPTH(swta_pkg::TABLE_ENTRIES)) u_score (
    .clk   (clk),
    .we    (sc_we),
    .waddr (sc_waddr),
    .wdata (sc_wdata),
    .raddr (rd_r[swta_pkg::IDX_W-1:0]),
    .rdata (sc_q)
  );

  swta_rank u_rank (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (rank_cmd),
    .cap      (cap_r),
    .found    (found),
    .list_idx (list_idx),
    .list_sc  (list_sc)
  );

  assign {e_key, e_wlen, e_slen, e_seq, e_lang} = meta_q;

  assign in_tready = (state_r == swta_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_xfer  = out_tvalid && out_tready;
  assign issue     = (rd_r < fill_r);
  assign scan_done = !issue && !pend_r;
  assign learn_hit = pend_r && !query_r && e_lang == lang_r && e_wlen == wlen_r
                     && e_key == key_r;
  assign query_hit = pend_r && query_r && e_lang == lang_r && e_slen == slen_r
                     && e_seq == seq_r;
  assign cap_in    = (in_tdata[112:109] > 4'(swta_pkg::MAX_HITS))
                     ? 4'(swta_pkg::MAX_HITS) : in_tdata[112:109];
  assign query_ok  = cap_in != 4'd0 && in_tdata[38:34] != 5'd0
                     && in_tdata[38:34] <= swta_pkg::MAX_LETTERS;
  assign bump_sc   = (hit_sc_r < swta_pkg::SCORE_LIMIT) ? hit_sc_r + 8'd1 : hit_sc_r;
  assign halve_in  = (state_r == swta_pkg::ST_BUMP) ? bump_sc : sc_q;
  assign halve_out = (halve_in[7:1] == 7'd0) ? 8'd1 : {1'b0, halve_in[7:1]};
  assign out_last  = !query_r || found == '0 || ({1'b0, qk_r} + 1'b1) == found;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swta_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (swta_pkg::kind_t'(in_tuser))
            swta_pkg::KIND_LEARN: state_nxt = swta_pkg::ST_SCAN;
            swta_pkg::KIND_QUERY: state_nxt = query_ok ? swta_pkg::ST_SCAN
                                                       : swta_pkg::ST_RESP;
            swta_pkg::KIND_CLEAR: state_nxt = swta_pkg::ST_RESP;
            default:              state_nxt = swta_pkg::ST_IDLE;
          endcase
        end
      end
      swta_pkg::ST_SCAN: begin
        if (learn_hit) begin
          state_nxt = swta_pkg::ST_BUMP;
        end else if (scan_done) begin
          state_nxt = query_r ? swta_pkg::ST_RESP : swta_pkg::ST_INSERT;
        end
      end
      swta_pkg::ST_BUMP: begin
        state_nxt = (bump_sc >= swta_pkg::SCORE_LIMIT) ? swta_pkg::ST_HALVE
                                                      : swta_pkg::ST_RESP;
      end
      swta_pkg::ST_HALVE: begin
        if (scan_done) begin
          state_nxt = swta_pkg::ST_RESP;
        end
      end
      swta_pkg::ST_INSERT: state_nxt = swta_pkg::ST_RESP;
      swta_pkg::ST_RESP: begin
        if (out_xfer && out_last) begin
          state_nxt = swta_pkg::ST_IDLE;
        end
      end
      default: state_nxt = swta_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    meta_we        = 1'b0;
    meta_waddr     = hit_idx_r;
    meta_wdata     = {key_r, wlen_r, slen_r, seq_r, lang_r};
    sc_we          = 1'b0;
    sc_waddr       = hit_idx_r;
    sc_wdata       = bump_sc;
    rank_cmd.clr   = accept;
    rank_cmd.ins   = (state_r == swta_pkg::ST_SCAN) && query_hit;
    rank_cmd.idx   = 8'(pidx_r);
    rank_cmd.score = sc_q;
    out_tvalid     = (state_r == swta_pkg::ST_RESP);
    out_tlast      = out_last;
    out_tdata      = {res_sc_r, res_idx_r};
    out_tuser      = {1'b0, res_out_r};
    unique case (state_r)
      swta_pkg::ST_BUMP: begin
        sc_we = 1'b1;
      end
      swta_pkg::ST_HALVE: begin
        sc_we    = pend_r;
        sc_waddr = pidx_r;
        sc_wdata = halve_out;
      end
      swta_pkg::ST_INSERT: begin
        meta_we    = 1'b1;
        meta_waddr = (fill_r < swta_pkg::FILL_W'(swta_pkg::TABLE_ENTRIES))
                     ? fill_r[swta_pkg::IDX_W-1:0] : min_idx_r;
        sc_we      = 1'b1;
        sc_waddr   = meta_waddr;
        sc_wdata   = 8'd1;
      end
      swta_pkg::ST_RESP: begin
        if (query_r && found != '0) begin
          out_tdata = {list_sc[qk_r], list_idx[qk_r]};
          out_tuser = {1'b1, swta_pkg::OUT_QUERY};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swta_pkg::ST_IDLE;
      fill_r  <= '0;
      rd_r    <= '0;
      pend_r  <= 1'b0;
      qk_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept && swta_pkg::kind_t'(in_tuser) == swta_pkg::KIND_CLEAR) begin
        fill_r <= '0;
      end else if (state_r == swta_pkg::ST_INSERT
                   && fill_r < swta_pkg::FILL_W'(swta_pkg::TABLE_ENTRIES)) begin
        fill_r <= fill_r + 1'b1;
      end
      if (state_r == swta_pkg::ST_SCAN || state_r == swta_pkg::ST_HALVE) begin
        pend_r <= issue;
        if (issue) begin
          rd_r <= rd_r + 1'b1;
        end
      end else begin
        pend_r <= 1'b0;
        rd_r   <= '0;
      end
      if (accept) begin
        qk_r <= '0;
      end else if (state_r == swta_pkg::ST_RESP && out_xfer && !out_last) begin
        qk_r <= qk_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx_r <= rd_r[swta_pkg::IDX_W-1:0];
    if (accept) begin
      query_r   <= (swta_pkg::kind_t'(in_tuser) == swta_pkg::KIND_QUERY);
      lang_r    <= in_tdata[1:0];
      seq_r     <= in_tdata[33:2];
      slen_r    <= in_tdata[38:34];
      key_r     <= in_tdata[102:39];
      wlen_r    <= in_tdata[108:103];
      cap_r     <= cap_in;
      res_out_r <= (swta_pkg::kind_t'(in_tuser) == swta_pkg::KIND_CLEAR)
                   ? swta_pkg::OUT_CLEARED : swta_pkg::OUT_QUERY;
      res_idx_r <= 8'd0;
      res_sc_r  <= 8'd0;
      min_idx_r <= '0;
      min_sc_r  <= 8'd0;
    end
    if (state_r == swta_pkg::ST_SCAN && pend_r && !query_r) begin
      if (pidx_r == '0 || sc_q < min_sc_r) begin
        min_idx_r <= pidx_r;
        min_sc_r  <= sc_q;
      end
      hit_idx_r <= pidx_r;
      hit_sc_r  <= sc_q;
    end
    if (state_r == swta_pkg::ST_BUMP) begin
      res_out_r <= swta_pkg::OUT_BUMPED;
      res_idx_r <= 8'(hit_idx_r);
      res_sc_r  <= (bump_sc >= swta_pkg::SCORE_LIMIT) ? halve_out : bump_sc;
    end
    if (state_r == swta_pkg::ST_INSERT) begin
      res_out_r <= (fill_r < swta_pkg::FILL_W'(swta_pkg::TABLE_ENTRIES))
                   ? swta_pkg::OUT_INSERTED : swta_pkg::OUT_REPLACED;
      res_idx_r <= 8'(meta_waddr);
      res_sc_r  <= 8'd1;
    end
  end

  `SWTA_CHK_SAME(a_ready_excl, in_tready, !out_tvalid)
  `SWTA_CHK_SAME(a_fill_max, 1'b1, fill_r <= swta_pkg::FILL_W'(swta_pkg::TABLE_ENTRIES))
  `SWTA_CHK_NEXT(a_last_idle, out_tvalid && out_tready && out_tlast, in_tready)
  `SWTA_CHK_SAME(a_found_cap, 1'b1, found <= swta_pkg::CNT_W'(swta_pkg::MAX_HITS))
endmodule
`default_nettype wire

// ----- design/swta_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module swta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- design/swta_rank.sv -----
// Sorted list of query matches, highest score first, ties in arrival order.
// Depends on swta_pkg.
`default_nettype none
module swta_rank (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire swta_pkg::rank_cmd_t         cmd,
  input  wire logic [3:0]                  cap,
  output logic      [swta_pkg::CNT_W-1:0]  found,
  output logic      [7:0]                  list_idx [swta_pkg::MAX_HITS],
  output logic      [7:0]                  list_sc  [swta_pkg::MAX_HITS]
);
  logic [7:0]                 idx_r [swta_pkg::MAX_HITS];
  logic [7:0]                 sc_r  [swta_pkg::MAX_HITS];
  logic [7:0]                 idx_nxt [swta_pkg::MAX_HITS];
  logic [7:0]                 sc_nxt  [swta_pkg::MAX_HITS];
  logic [swta_pkg::CNT_W-1:0] found_r;
  logic [swta_pkg::CNT_W-1:0] found_nxt;
  logic [swta_pkg::CNT_W-1:0] pos;
  logic [swta_pkg::CNT_W-1:0] top;
  logic [swta_pkg::CNT_W-1:0] cap_w;

  assign cap_w = cap[swta_pkg::CNT_W-1:0];

  always_comb begin
    pos = '0;
    for (int k = 0; k < swta_pkg::MAX_HITS; k++) begin
      if (k < found_r && sc_r[k] >= cmd.score) begin
        pos = pos + 1'b1;
      end
    end
    top = (found_r < cap_w) ? found_r : cap_w - 1'b1;
    found_nxt = found_r;
    for (int k = 0; k < swta_pkg::MAX_HITS; k++) begin
      idx_nxt[k] = idx_r[k];
      sc_nxt[k]  = sc_r[k];
    end
    if (cmd.ins && pos < cap_w) begin
      for (int k = 1; k < swta_pkg::MAX_HITS; k++) begin
        if (k > pos && k <= top) begin
          idx_nxt[k] = idx_r[k-1];
          sc_nxt[k]  = sc_r[k-1];
        end
      end
      for (int k = 0; k < swta_pkg::MAX_HITS; k++) begin
        if (k == pos) begin
          idx_nxt[k] = cmd.idx;
          sc_nxt[k]  = cmd.score;
        end
      end
      if (found_r < cap_w) begin
        found_nxt = found_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= '0;
    end else if (cmd.clr) begin
      found_r <= '0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < swta_pkg::MAX_HITS; k++) begin
      idx_r[k] <= idx_nxt[k];
      sc_r[k]  <= sc_nxt[k];
    end
  end

  assign found = found_r;
  always_comb begin
    for (int k = 0; k < swta_pkg::MAX_HITS; k++) begin
      list_idx[k] = idx_r[k];
      list_sc[k]  = sc_r[k];
    end
  end
endmodule
`default_nettype wire
